// ----- rtl/core/dafs_pkg.sv -----
// Shared types, constants and the helper function of the arming and failsafe supervisor.
package dafs_pkg;

  // Default number of battery taps that are graded.
  localparam int unsigned CELL_COUNT_DEF = 3;
  // Number of tap inputs on the port list.
  localparam int unsigned TAPS_MAX = 4;
  // Tap counter width; it holds 0 up to TAPS_MAX.
  localparam int unsigned TAP_CNT_W = 3;
  // Tap select width into the four tap readings.
  localparam int unsigned TAP_SEL_W = 2;

  // Field widths.
  localparam int unsigned STICK_W = 12;
  localparam int unsigned ADC_W = 10;
  localparam int unsigned TOL_W = 8;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned REP_W = 16;
  // adc * 100 needs 17 bits, times the gain 33 bits.
  localparam int unsigned ADCX_W = 17;
  localparam int unsigned PROD_W = 33;

  // Radio thresholds.
  localparam logic [STICK_W-1:0] SWITCH_LEVEL = 12'd1250;
  localparam logic [REP_W-1:0] REPEAT_LIMIT = 16'd50000;
  // Unity gain in Q4.12 for the first tap.
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

  // Cell thresholds as (T + 500) / 50, so both sides of a test are divided by 50.
  localparam logic [6:0] K_CRIT_HI = 7'd78;  // 3400 mV
  localparam logic [6:0] K_CRIT_LO = 7'd50;  // 2000 mV
  localparam logic [6:0] K_LOW = 7'd83;      // 3650 mV
  localparam logic [6:0] K_MID = 7'd87;      // 3850 mV

  // Configuration register indexes.
  localparam logic CFG_STICK_TOL = 1'b0;
  localparam logic CFG_DIV_GAIN = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

  // Battery grades; a lower code is more severe.
  typedef enum logic [1:0] {
    GRADE_CRIT = 2'd0,
    GRADE_LOW  = 2'd1,
    GRADE_MID  = 2'd2,
    GRADE_OK   = 2'd3
  } grade_e;

  // Flight state codes.
  typedef enum logic [2:0] {
    ST_STANDBY  = 3'd0,
    ST_FLYING   = 3'd1,
    ST_NOCMD    = 3'd2,
    ST_LOWBATT  = 3'd3,
    ST_CRITBATT = 3'd4,
    ST_NONE     = 3'd7
  } flight_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;     // capture the input transaction
    logic                 mul_en;   // form the scaled product of one tap
    logic [TAP_SEL_W-1:0] mul_tap;  // tap index for the product
    logic                 cmp_en;   // grade the product held from the last cycle
    logic [TAP_CNT_W-1:0] cmp_n;    // tap number (index plus one) being graded
    logic                 commit;   // decide, update state, load the result
  } dafs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic crit_seen;  // a tap graded critical; remaining taps are skipped
  } dafs_status_t;

  // Right side of a cell test: n * k * 2^22.
  function automatic logic [PROD_W-1:0] cell_thr(input logic [TAP_CNT_W-1:0] n,
                                                  input logic [6:0] k);
    logic [PROD_W-1:0] nk;
    nk = PROD_W'(n) * PROD_W'(k);
    return nk << 22;
  endfunction

endpackage

// ----- rtl/core/dafs_ctrl.sv -----
// Controller state machine that sequences capture, tap grading and result delivery.
module dafs_ctrl
  import dafs_pkg::*;
#(
  parameter int unsigned CellCount = CELL_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  dafs_status_t status_i,
  output dafs_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GRADE  = 3'b010,
    S_DECIDE = 3'b100
  } ctrl_state_e;

  localparam logic [TAP_CNT_W-1:0] LastCnt = TAP_CNT_W'(CellCount);

  ctrl_state_e          state_q, state_d;
  logic [TAP_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  // The result register can take a new value when empty or drained this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state, tap counter and datapath commands.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = '0;
          state_d = S_GRADE;
        end
      end
      S_GRADE: begin
        // The multiplier works on tap cnt while the compare grades tap cnt-1.
        cmd_o.mul_en = (cnt_q < LastCnt);
        cmd_o.mul_tap = cnt_q[TAP_SEL_W-1:0];
        cmd_o.cmp_en = (cnt_q != '0);
        cmd_o.cmp_n = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastCnt || status_i.crit_seen) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/dafs_datapath.sv -----
// Datapath: input capture, tap multiplier and grading, radio decision and held state.
module dafs_datapath
  import dafs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  frame_synced_i,
  input  logic [STICK_W-1:0]    aileron_us_i,
  input  logic [STICK_W-1:0]    elevator_us_i,
  input  logic [STICK_W-1:0]    throttle_us_i,
  input  logic [STICK_W-1:0]    rudder_us_i,
  input  logic [STICK_W-1:0]    arm_switch_us_i,
  input  logic [STICK_W-1:0]    override_switch_us_i,
  input  logic [ADC_W-1:0]      cell0_adc_i,
  input  logic [ADC_W-1:0]      cell1_adc_i,
  input  logic [ADC_W-1:0]      cell2_adc_i,
  input  logic [ADC_W-1:0]      cell3_adc_i,
  input  dafs_cmd_t             cmd_i,
  output dafs_status_t          status_o,
  output logic [2:0]            flight_state_o
);

  // Configuration registers.
  logic [TOL_W-1:0]  tol_q;
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STICK_TOL: tol_q <= cfg_data_i[TOL_W-1:0];
        CFG_DIV_GAIN:  gain_q <= cfg_data_i[GAIN_W-1:0];
        default: begin
          tol_q <= tol_q;
        end
      endcase
    end
  end

  // Captured transaction; payload only.
  logic               synced_q;
  logic [STICK_W-1:0] stick_q [TAPS_MAX];
  logic [STICK_W-1:0] arm_q, ovr_q;
  logic [ADC_W-1:0]   adc_q [TAPS_MAX];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      synced_q <= frame_synced_i;
      stick_q[0] <= aileron_us_i;
      stick_q[1] <= elevator_us_i;
      stick_q[2] <= throttle_us_i;
      stick_q[3] <= rudder_us_i;
      arm_q <= arm_switch_us_i;
      ovr_q <= override_switch_us_i;
      adc_q[0] <= cell0_adc_i;
      adc_q[1] <= cell1_adc_i;
      adc_q[2] <= cell2_adc_i;
      adc_q[3] <= cell3_adc_i;
    end
  end

  // Tap multiplier: (adc * 100) * gain, registered before the compare.
  logic [ADC_W-1:0]  adc_sel;
  logic [ADCX_W-1:0] adc_x100;
  logic [GAIN_W-1:0] gain_sel;
  logic [PROD_W-1:0] prod_q;

  assign adc_sel = adc_q[cmd_i.mul_tap];
  assign adc_x100 = (ADCX_W'(adc_sel) << 6) + (ADCX_W'(adc_sel) << 5) +
                    (ADCX_W'(adc_sel) << 2);
  assign gain_sel = (cmd_i.mul_tap == '0) ? GAIN_UNITY : gain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(adc_x100) * PROD_W'(gain_sel);
    end
  end

  // Tap grading; a critical tap freezes the grade for the rest of the item.
  logic   below_crit_hi, above_crit_lo, below_low, below_mid;
  grade_e grade_q, grade_d;
  logic   crit_q, crit_d;

  assign below_crit_hi = prod_q < cell_thr(cmd_i.cmp_n, K_CRIT_HI);
  assign above_crit_lo = prod_q > cell_thr(cmd_i.cmp_n, K_CRIT_LO);
  assign below_low = prod_q < cell_thr(cmd_i.cmp_n, K_LOW);
  assign below_mid = prod_q < cell_thr(cmd_i.cmp_n, K_MID);

  always_comb begin
    grade_d = grade_q;
    crit_d = crit_q;
    if (cmd_i.load) begin
      grade_d = GRADE_OK;
      crit_d = 1'b0;
    end else if (cmd_i.cmp_en && !crit_q) begin
      if (below_crit_hi && above_crit_lo) begin
        grade_d = GRADE_CRIT;
        crit_d = 1'b1;
      end else if (below_low) begin
        grade_d = GRADE_LOW;
      end else if (below_mid) begin
        grade_d = GRADE_MID;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grade_q <= GRADE_OK;
      crit_q <= 1'b0;
    end else begin
      grade_q <= grade_d;
      crit_q <= crit_d;
    end
  end

  assign status_o.crit_seen = crit_q;

  // Radio decision from the captured frame and the stick history.
  logic [STICK_W-1:0] last_q [TAPS_MAX];
  logic [REP_W-1:0]   rep_q;
  flight_e            held_q;
  logic [2:0]         flight_q;

  logic [TAPS_MAX-1:0] same;
  logic [STICK_W-1:0]  diff [TAPS_MAX];
  logic [REP_W-1:0]    rep_inc;
  logic                armed, repeat_hit, do_store, radio_path;
  flight_e             radio_st, step_st, out_st;

  always_comb begin
    for (int i = 0; i < TAPS_MAX; i++) begin
      diff[i] = (stick_q[i] > last_q[i]) ? stick_q[i] - last_q[i]
                                          : last_q[i] - stick_q[i];
      same[i] = diff[i] <= STICK_W'(tol_q);
    end
  end

  assign armed = arm_q > SWITCH_LEVEL;
  assign repeat_hit = armed && (ovr_q < SWITCH_LEVEL) && (&same);
  assign rep_inc = rep_q + 1'b1;

  always_comb begin
    if (!synced_q) begin
      radio_st = ST_NONE;
    end else if (!armed) begin
      radio_st = ST_STANDBY;
    end else if (repeat_hit && (rep_inc > REPEAT_LIMIT)) begin
      radio_st = ST_NOCMD;
    end else begin
      radio_st = ST_FLYING;
    end
  end

  // The battery grade overrides the radio; the radio is examined only when it is fine.
  always_comb begin
    radio_path = 1'b0;
    case (grade_q)
      GRADE_CRIT: step_st = ST_CRITBATT;
      GRADE_LOW:  step_st = ST_LOWBATT;
      default: begin
        step_st = radio_st;
        radio_path = 1'b1;
      end
    endcase
  end

  assign do_store = radio_path && synced_q && !repeat_hit;

  // An unsynchronized frame repeats the held state, or standby if none is held.
  assign out_st = (step_st != ST_NONE) ? step_st :
                  ((held_q == ST_NONE) ? ST_STANDBY : held_q);

  // State update and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= ST_NONE;
      rep_q <= '0;
      for (int i = 0; i < TAPS_MAX; i++) begin
        last_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (step_st != ST_NONE) begin
        held_q <= step_st;
      end
      if (do_store) begin
        rep_q <= '0;
        for (int i = 0; i < TAPS_MAX; i++) begin
          last_q[i] <= stick_q[i];
        end
      end else if (radio_path && synced_q) begin
        rep_q <= rep_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      flight_q <= out_st;
    end
  end

  assign flight_state_o = flight_q;

endmodule

// ----- rtl/core/drone_arming_failsafe_supervisor.sv -----
// Top level of the drone arming and failsafe supervisor.
// Transactions do not overlap: a new one is accepted only after the last is committed. The shared tap multiplier
// and compare grade one battery tap per cycle; a critical tap ends grading early.
// The result register holds a finished result while the next transaction is accepted.
// Asynchronous active-low reset: held state none, stick store and repeat count zero.
module drone_arming_failsafe_supervisor
  import dafs_pkg::*;
#(
  parameter int unsigned CellCount = CELL_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  frame_synced_i,
  input  logic [STICK_W-1:0]    aileron_us_i,
  input  logic [STICK_W-1:0]    elevator_us_i,
  input  logic [STICK_W-1:0]    throttle_us_i,
  input  logic [STICK_W-1:0]    rudder_us_i,
  input  logic [STICK_W-1:0]    arm_switch_us_i,
  input  logic [STICK_W-1:0]    override_switch_us_i,
  input  logic [ADC_W-1:0]      cell0_adc_i,
  input  logic [ADC_W-1:0]      cell1_adc_i,
  input  logic [ADC_W-1:0]      cell2_adc_i,
  input  logic [ADC_W-1:0]      cell3_adc_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            flight_state_o
);

  dafs_cmd_t    cmd;
  dafs_status_t status;

  // Sequencer.
  dafs_ctrl #(
    .CellCount(CellCount)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  dafs_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .frame_synced_i      (frame_synced_i),
    .aileron_us_i        (aileron_us_i),
    .elevator_us_i       (elevator_us_i),
    .throttle_us_i       (throttle_us_i),
    .rudder_us_i         (rudder_us_i),
    .arm_switch_us_i     (arm_switch_us_i),
    .override_switch_us_i(override_switch_us_i),
    .cell0_adc_i         (cell0_adc_i),
    .cell1_adc_i         (cell1_adc_i),
    .cell2_adc_i         (cell2_adc_i),
    .cell3_adc_i         (cell3_adc_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .flight_state_o      (flight_state_o)
  );

endmodule

// ----- rtl/core/dafs_checker.sv -----
// Port-level checker of the supervisor and its bind to the top level.
module dafs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] flight_state_o
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(flight_state_o))
    else $error("stalled result changed");

  // Every offered result is a defined flight state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flight_state_o <= 3'd4)
    else $error("undefined flight state offered");

  // After a transaction is accepted the block is busy grading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted during grading");

  // A new result appears only at the end of processing, when input was closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result produced without processing");

endmodule

bind drone_arming_failsafe_supervisor dafs_checker u_dafs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .flight_state_o(flight_state_o)
);

// ----- tb/tb.sv -----
// Self-checking testbench of the drone arming and failsafe supervisor.
`timescale 1ns / 100ps

module tb;
  import dafs_pkg::*;

  localparam int unsigned CellCount = CELL_COUNT_DEF;
  localparam int unsigned TapsGraded = (CellCount > TAPS_MAX) ? TAPS_MAX : CellCount;
  // Cycles to let pass after the last result before the block counts as idle.
  localparam int unsigned DrainCycles = CellCount + 8;

  // Cell voltage thresholds in millivolts and the per-tap offset.
  localparam int unsigned CRIT_HI_MV = 3400;
  localparam int unsigned CRIT_LO_MV = 2000;
  localparam int unsigned LOW_MV = 3650;
  localparam int unsigned MID_MV = 3850;
  localparam int unsigned TAP_OFFSET_MV = 500;
  // A divider gain of 3.0 lets taps 0 to 2 reach a healthy cell voltage.
  localparam logic [GAIN_W-1:0] GAIN_HEALTHY = 16'd12288;
  // Tap readings, leftmost is tap 3; taps 0 to 2 are healthy at a gain of 3.0.
  localparam logic [3:0][ADC_W-1:0] TAPS_GOOD = {4{10'd1000}};

  // One radio frame.
  typedef struct packed {
    logic                         synced;
    logic [3:0][STICK_W-1:0]      sticks;  // aileron, elevator, throttle, rudder
    logic [STICK_W-1:0]           arm_us;
    logic [STICK_W-1:0]           ovr_us;
    logic [3:0][ADC_W-1:0]        adc;
  } frame_t;

  // Block inputs, all known from time zero.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_index_i = CFG_STICK_TOL;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  frame_synced_i = 1'b0;
  logic [STICK_W-1:0]    aileron_us_i = '0;
  logic [STICK_W-1:0]    elevator_us_i = '0;
  logic [STICK_W-1:0]    throttle_us_i = '0;
  logic [STICK_W-1:0]    rudder_us_i = '0;
  logic [STICK_W-1:0]    arm_switch_us_i = '0;
  logic [STICK_W-1:0]    override_switch_us_i = '0;
  logic [ADC_W-1:0]      cell0_adc_i = '0;
  logic [ADC_W-1:0]      cell1_adc_i = '0;
  logic [ADC_W-1:0]      cell2_adc_i = '0;
  logic [ADC_W-1:0]      cell3_adc_i = '0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [2:0]            flight_state_o;

  // Supervisor state and configuration as the testbench tracks them.
  logic [TOL_W-1:0]        tol_q = TOL_RESET;
  logic [GAIN_W-1:0]       gain_q = GAIN_RESET;
  flight_e                 held_q = ST_NONE;
  logic [3:0][STICK_W-1:0] stick_store_q = '0;
  logic [REP_W-1:0]        repeat_q = '0;

  // Expected flight states in order of acceptance.
  flight_e flight_exp_q[$];
  int unsigned err_count = 0;

  // Idle control of both sides.
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned rx_hold_len = 0;
  int unsigned rx_wait = 0;

  drone_arming_failsafe_supervisor #(
    .CellCount(CellCount)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .frame_synced_i      (frame_synced_i),
    .aileron_us_i        (aileron_us_i),
    .elevator_us_i       (elevator_us_i),
    .throttle_us_i       (throttle_us_i),
    .rudder_us_i         (rudder_us_i),
    .arm_switch_us_i     (arm_switch_us_i),
    .override_switch_us_i(override_switch_us_i),
    .cell0_adc_i         (cell0_adc_i),
    .cell1_adc_i         (cell1_adc_i),
    .cell2_adc_i         (cell2_adc_i),
    .cell3_adc_i         (cell3_adc_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .flight_state_o      (flight_state_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Right side of a cell test: the scaled tap reading is compared against this.
  function automatic logic [63:0] cell_limit(input logic [63:0] n, input int unsigned mv);
    return (n * 64'(mv + TAP_OFFSET_MV)) << 22;
  endfunction

  // Predicts the flight state of one accepted frame and advances the tracked state.
  function automatic flight_e predict_flight(input frame_t f);
    grade_e       grade;
    flight_e      st;
    logic [63:0]  scaled;
    logic [63:0]  n;
    logic [STICK_W-1:0] diff;
    logic         rep_hit;
    grade = GRADE_OK;
    // Grade the taps in order; a critical tap ends grading.
    for (int k = 0; k < TapsGraded; k++) begin
      scaled = 64'(f.adc[k]) * 64'd5000 * ((k == 0) ? 64'(GAIN_UNITY) : 64'(gain_q));
      n = 64'(k + 1);
      if (scaled < cell_limit(n, CRIT_HI_MV) && scaled > cell_limit(n, CRIT_LO_MV)) begin
        grade = GRADE_CRIT;
        break;
      end else if (scaled < cell_limit(n, LOW_MV)) begin
        grade = GRADE_LOW;
      end else if (scaled < cell_limit(n, MID_MV)) begin
        grade = GRADE_MID;
      end
    end
    if (grade == GRADE_CRIT) begin
      st = ST_CRITBATT;
    end else if (grade == GRADE_LOW) begin
      st = ST_LOWBATT;
    end else if (!f.synced) begin
      st = ST_NONE;
    end else begin
      // Radio decision with repeat detection on the four sticks.
      rep_hit = 1'b0;
      if (f.arm_us > SWITCH_LEVEL) begin
        st = ST_FLYING;
        if (f.ovr_us < SWITCH_LEVEL) begin
          rep_hit = 1'b1;
          for (int i = 0; i < 4; i++) begin
            diff = (f.sticks[i] > stick_store_q[i]) ? f.sticks[i] - stick_store_q[i]
                                                     : stick_store_q[i] - f.sticks[i];
            if (diff > STICK_W'(tol_q)) rep_hit = 1'b0;
          end
          if (rep_hit) begin
            repeat_q = repeat_q + 1'b1;
            if (repeat_q > REPEAT_LIMIT) st = ST_NOCMD;
          end
        end
      end else begin
        st = ST_STANDBY;
      end
      if (!rep_hit) begin
        stick_store_q = f.sticks;
        repeat_q = '0;
      end
    end
    // Unsynchronized frames repeat the last decided state.
    if (st == ST_NONE) begin
      st = (held_q == ST_NONE) ? ST_STANDBY : held_q;
    end else begin
      held_q = st;
    end
    return st;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // A tap reading whose cell voltage is at least the mid threshold, when one exists.
  function automatic logic [ADC_W-1:0] healthy_adc(input int unsigned tap);
    logic [63:0] per_count;
    logic [63:0] need;
    per_count = 64'd5000 * ((tap == 0) ? 64'(GAIN_UNITY) : 64'(gain_q));
    if (per_count == 0) return $urandom_range(1023, 0);
    need = (cell_limit(64'(tap + 1), MID_MV) + per_count - 1) / per_count;
    if (need > 64'd1023) return $urandom_range(1023, 0);
    return $urandom_range(1023, int'(need));
  endfunction

  function automatic logic [3:0][ADC_W-1:0] healthy_taps();
    logic [3:0][ADC_W-1:0] a;
    for (int k = 0; k < 4; k++) a[k] = healthy_adc(k);
    return a;
  endfunction

  // A stick value inside or just outside the tolerance around the stored value.
  function automatic logic [STICK_W-1:0] stick_near(input logic [STICK_W-1:0] base,
                                                    input bit within_tol);
    int d;
    int v;
    d = within_tol ? int'($urandom_range(tol_q, 0))
                   : int'($urandom_range(tol_q + 40, tol_q + 1));
    v = $urandom_range(1, 0) ? int'(base) + d : int'(base) - d;
    if (v < 0 || v > 4095) v = (v < 0) ? int'(base) + d : int'(base) - d;
    return v[STICK_W-1:0];
  endfunction

  function automatic frame_t make_frame(input logic synced, input int unsigned arm,
                                        input int unsigned ovr,
                                        input logic [3:0][STICK_W-1:0] sticks,
                                        input logic [3:0][ADC_W-1:0] adc);
    frame_t f;
    f.synced = synced;
    f.arm_us = arm[STICK_W-1:0];
    f.ovr_us = ovr[STICK_W-1:0];
    f.sticks = sticks;
    f.adc = adc;
    return f;
  endfunction

  // A random frame, biased toward repeats and switch edges.
  function automatic frame_t random_frame();
    frame_t f;
    int unsigned r;
    f.synced = ($urandom_range(99, 0) < 85);
    r = $urandom_range(99, 0);
    for (int i = 0; i < 4; i++) begin
      if (r < 50) f.sticks[i] = stick_near(stick_store_q[i], 1'b1);
      else if (r < 65) f.sticks[i] = stick_near(stick_store_q[i], $urandom_range(3, 0) != 0);
      else if (r < 70) f.sticks[i] = $urandom_range(1, 0) ? '1 : '0;
      else f.sticks[i] = $urandom_range(4095, 0);
    end
    r = $urandom_range(99, 0);
    if (r < 20) f.arm_us = $urandom_range(1252, 1248);
    else if (r < 60) f.arm_us = $urandom_range(4095, 1251);
    else f.arm_us = $urandom_range(4095, 0);
    r = $urandom_range(99, 0);
    if (r < 20) f.ovr_us = $urandom_range(1252, 1248);
    else if (r < 70) f.ovr_us = $urandom_range(1249, 0);
    else f.ovr_us = $urandom_range(4095, 0);
    if ($urandom_range(99, 0) < 75) begin
      f.adc = healthy_taps();
    end else begin
      for (int k = 0; k < 4; k++) f.adc[k] = $urandom_range(1023, 0);
    end
    return f;
  endfunction

  // Offers one frame, waits for its transaction and records the expected state.
  // Valid stays high on return unless a gap was inserted.
  task automatic send_frame(input frame_t f);
    int unsigned gap;
    in_valid_i           <= 1'b1;
    frame_synced_i       <= f.synced;
    aileron_us_i         <= f.sticks[0];
    elevator_us_i        <= f.sticks[1];
    throttle_us_i        <= f.sticks[2];
    rudder_us_i          <= f.sticks[3];
    arm_switch_us_i      <= f.arm_us;
    override_switch_us_i <= f.ovr_us;
    cell0_adc_i          <= f.adc[0];
    cell1_adc_i          <= f.adc[1];
    cell2_adc_i          <= f.adc[2];
    cell3_adc_i          <= f.adc[3];
    do @(posedge clk_i); while (!in_ready_o);
    flight_exp_q.push_back(predict_flight(f));
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering frames and waits until the block has delivered everything.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (flight_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes one configuration register while the block is idle.
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_STICK_TOL) tol_q = value[TOL_W-1:0];
    else gain_q = value[GAIN_W-1:0];
    @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (flight_exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result flight_state=%0d", $realtime, flight_state_o);
      end else begin
        if (flight_state_o !== flight_exp_q[0]) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: flight_state mismatch: expected %0d, actual %0d",
                     $realtime, flight_exp_q[0], flight_state_o);
        end
        void'(flight_exp_q.pop_front());
      end
    end
  end

  // Receiver ready with random idles and a long hold-off on request.
  always @(posedge clk_i) begin
    if (rx_hold_len != 0) begin
      rx_wait = rx_hold_len;
      rx_hold_len = 0;
    end
    if (rx_wait != 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (rx_gaps_on && $urandom_range(5, 0) == 0) rx_wait = pick_gap();
    end
  end

  // Nothing is held after reset, so an unsynchronized frame reads standby.
  task automatic test_unsynced_start();
    write_reg(CFG_DIV_GAIN, GAIN_HEALTHY);
    send_frame(make_frame(1'b0, 2000, 0, {4{12'd1500}}, TAPS_GOOD));
    send_frame(make_frame(1'b1, 1251, 1250, {4{12'd1500}}, TAPS_GOOD));
    send_frame(make_frame(1'b0, 0, 0, {4{12'd0}}, TAPS_GOOD));
    send_frame(make_frame(1'b1, 1250, 1250, {4{12'd1500}}, TAPS_GOOD));
  endtask

  // Repeat detection, tolerance edges and the switch thresholds.
  task automatic test_radio_rules();
    send_frame(make_frame(1'b1, 4095, 0, {4{12'd1500}}, TAPS_GOOD));
    send_frame(make_frame(1'b1, 4095, 1249, {12'd1500, 12'd1500, 12'd1490, 12'd1510},
                          TAPS_GOOD));
    send_frame(make_frame(1'b1, 4095, 1249, {12'd1500, 12'd1511, 12'd1500, 12'd1500},
                          TAPS_GOOD));
    send_frame(make_frame(1'b1, 0, 4095, {4{12'd0}}, TAPS_GOOD));
    send_frame(make_frame(1'b1, 4095, 0, {4{12'hFFF}}, TAPS_GOOD));
    // A low battery frame must leave the stick store and count alone.
    send_frame(make_frame(1'b1, 4095, 0, {4{12'd100}}, {10'd1000, 10'd0, 10'd1000, 10'd1000}));
    send_frame(make_frame(1'b1, 4095, 0, {4{12'hFFF}}, TAPS_GOOD));
  endtask

  // Tap thresholds on the first tap, and later taps overriding earlier grades.
  task automatic test_battery_grades();
    int unsigned edge_adc[8] = '{512, 513, 798, 799, 849, 850, 890, 891};
    foreach (edge_adc[i])
      send_frame(make_frame(1'b1, 2000, 2000, {4{12'd1500}},
                            {10'd1000, 10'd1000, 10'd1000, 10'(edge_adc[i])}));
    // Mid first tap, low third tap: low wins.
    send_frame(make_frame(1'b1, 2000, 2000, {4{12'd1500}}, {10'd1000, 10'd0, 10'd1000, 10'd860}));
    // Critical first tap stops grading before a low second tap.
    send_frame(make_frame(1'b1, 2000, 2000, {4{12'd1500}}, {10'd1000, 10'd1000, 10'd560, 10'd700}));
    // Healthy later taps leave a low grade in place.
    send_frame(make_frame(1'b1, 2000, 2000, {4{12'd1500}}, {10'd0, 10'd1000, 10'd1000, 10'd820}));
    // Unsynchronized frame after a battery state holds that state.
    send_frame(make_frame(1'b0, 2000, 2000, {4{12'd1500}}, TAPS_GOOD));
    send_frame(make_frame(1'b1, 2000, 2000, {4{12'd1500}}, {4{10'h3FF}}));
  endtask

  // Register extremes, including a gain below unity.
  task automatic test_config_extremes();
    write_reg(CFG_DIV_GAIN, GAIN_UNITY);
    send_frame(make_frame(1'b1, 2000, 0, {4{12'd1500}}, {4{10'h3FF}}));
    write_reg(CFG_DIV_GAIN, 16'd0);
    send_frame(make_frame(1'b1, 2000, 0, {4{12'd1500}}, {4{10'h3FF}}));
    write_reg(CFG_DIV_GAIN, 16'hFFFF);
    write_reg(CFG_STICK_TOL, 16'd0);
    send_frame(make_frame(1'b1, 0, 0, {4{12'd2000}}, healthy_taps()));
    send_frame(make_frame(1'b1, 2000, 0, {4{12'd2000}}, healthy_taps()));
    send_frame(make_frame(1'b1, 2000, 0, {12'd2000, 12'd2000, 12'd2001, 12'd2000}, healthy_taps()));
    write_reg(CFG_STICK_TOL, 16'd255);
    send_frame(make_frame(1'b1, 0, 0, {4{12'd2000}}, healthy_taps()));
    send_frame(make_frame(1'b1, 2000, 0, {4{12'd2255}}, healthy_taps()));
    send_frame(make_frame(1'b1, 2000, 0, {4{12'd1744}}, healthy_taps()));
    write_reg(CFG_STICK_TOL, 16'(TOL_RESET));
    write_reg(CFG_DIV_GAIN, GAIN_HEALTHY);
  endtask

  // The receiver holds off while frames keep coming, then the sender pauses.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_len = 300;
    repeat (12) send_frame(random_frame());
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  // Run of repeated sticks back to back; the repeat count keeps climbing.
  task automatic test_repeat_run();
    frame_t f;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_frame(make_frame(1'b1, 0, 0, {4{12'd2000}}, healthy_taps()));
    repeat (60) begin
      for (int i = 0; i < 4; i++) f.sticks[i] = stick_near(stick_store_q[i], 1'b1);
      f.synced = 1'b1;
      f.arm_us = $urandom_range(4095, 1251);
      f.ovr_us = $urandom_range(1249, 0);
      f.adc = healthy_taps();
      send_frame(f);
    end
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Random frames over several register settings, with idle stretches switched on and off.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned per_phase;
    per_phase = n_items / 6;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_STICK_TOL, 16'(TOL_RESET));
          write_reg(CFG_DIV_GAIN, GAIN_HEALTHY);
        end
        1: begin
          write_reg(CFG_STICK_TOL, 16'd0);
          write_reg(CFG_DIV_GAIN, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_STICK_TOL, 16'd255);
          write_reg(CFG_DIV_GAIN, 16'($urandom_range(65535, 4096)));
        end
        3: begin
          write_reg(CFG_STICK_TOL, 16'($urandom_range(255, 0)));
          write_reg(CFG_DIV_GAIN, GAIN_UNITY);
        end
        4: begin
          write_reg(CFG_STICK_TOL, 16'($urandom_range(255, 0)));
          write_reg(CFG_DIV_GAIN, 16'($urandom_range(65535, 0)));
        end
        default: begin
          write_reg(CFG_STICK_TOL, 16'($urandom_range(40, 0)));
          write_reg(CFG_DIV_GAIN, 16'($urandom_range(20000, 8192)));
        end
      endcase
      for (int i = 0; i < per_phase; i++) begin
        if (i % 40 == 0) begin
          tx_gaps_on = ($urandom_range(3, 0) != 0);
          rx_gaps_on = ($urandom_range(3, 0) != 0);
        end
        send_frame(random_frame());
      end
    end
    wait_drained();
  endtask

  // Test sequence and verdict.
  initial begin
    int unsigned wait_cnt;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unsynced_start();
    test_radio_rules();
    test_battery_grades();
    test_config_extremes();
    test_backpressure();
    test_repeat_run();
    test_random_traffic(744);
    in_valid_i <= 1'b0;
    wait_cnt = 0;
    while (flight_exp_q.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    if (flight_exp_q.size() != 0) begin
      $display("%0d expected results never arrived", flight_exp_q.size());
      err_count += flight_exp_q.size();
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
